### rtl/lprf_pkg.sv
// ----------------------------------------------------------------------------
// lprf_pkg
// Shared types and codes for the length-prefixed record FIFO.
// ----------------------------------------------------------------------------
package lprf_pkg;

  // Request codes on the input channel
  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_PEEK   = 2'd2;

  // Status codes on the result channel
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  // Record length and read count width, and the hard cap on bytes per read
  localparam int LEN_W    = 7;
  localparam int MAX_READ = 64;

  typedef logic [1:0]       req_t;
  typedef logic [7:0]       byte_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [1:0]       stat_t;

  // Classified operation handed from the front to the back
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PEEK   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef struct packed {
    op_t   op;
    byte_t data;
    logic  last;
    len_t  limit;
  } cmd_t;

  typedef struct packed {
    byte_t out_byte;
    logic  byte_valid;
    logic  run_last;
    stat_t status;
    logic  queue_empty;
  } res_t;

endpackage

### rtl/lprf_if.sv
// ----------------------------------------------------------------------------
// lprf_in_if / lprf_out_if
// Valid/ready channels for requests into and results out of the record FIFO.
// ----------------------------------------------------------------------------
interface lprf_in_if;
  logic           valid;
  logic           ready;
  lprf_pkg::req_t  req_type;
  lprf_pkg::byte_t data_byte;
  logic           push_last;
  lprf_pkg::len_t  read_limit;

  modport source (output valid, req_type, data_byte, push_last, read_limit,
                  input ready);
  modport sink   (input valid, req_type, data_byte, push_last, read_limit,
                  output ready);
endinterface

interface lprf_out_if;
  logic            valid;
  logic            ready;
  lprf_pkg::byte_t  out_byte;
  logic            byte_valid;
  logic            run_last;
  lprf_pkg::stat_t  status;
  logic            queue_empty;

  modport source (output valid, out_byte, byte_valid, run_last, status,
                  queue_empty, input ready);
  modport sink   (input valid, out_byte, byte_valid, run_last, status,
                  queue_empty, output ready);
endinterface

### rtl/lprf_front.sv
// ----------------------------------------------------------------------------
// lprf_front
// Accept requests, classify them into operations and buffer them in a
// two-entry queue ahead of the execution back end.
// ----------------------------------------------------------------------------
module lprf_front (
  input  logic              clk,
  input  logic              rst_n,
  lprf_in_if.sink           in_ch,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output lprf_pkg::cmd_t    cmd
);

  lprf_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  lprf_pkg::cmd_t dec;
  logic           push, pop;

  // Classify the incoming request
  always_comb begin
    dec.data  = in_ch.data_byte;
    dec.last  = in_ch.push_last;
    dec.limit = in_ch.read_limit;
    unique case (in_ch.req_type)
      lprf_pkg::REQ_PUSH:   dec.op = lprf_pkg::OP_PUSH;
      lprf_pkg::REQ_REMOVE: dec.op = lprf_pkg::OP_REMOVE;
      lprf_pkg::REQ_PEEK:   dec.op = lprf_pkg::OP_PEEK;
      default:              dec.op = lprf_pkg::OP_NOP;
    endcase
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_r[rd_ptr_r];

  // Advance queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Hold queued operations
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

endmodule

### rtl/lprf_back.sv
// ----------------------------------------------------------------------------
// lprf_back
// Execute queued operations against the circular byte store: append record
// bytes, commit headers, and stream out the oldest record through a result
// register.
// ----------------------------------------------------------------------------
module lprf_back #(
  parameter int STORE_BYTES = 256,
  parameter int MAX_RECORD  = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  lprf_pkg::cmd_t cmd,
  lprf_out_if.source     out_ch
);

  localparam int AW  = $clog2(STORE_BYTES);
  localparam int UW  = $clog2(STORE_BYTES + 1);
  localparam int SW  = ((UW > lprf_pkg::LEN_W) ? UW : lprf_pkg::LEN_W) + 1;
  localparam int W2  = (UW > 9) ? UW : 9;
  localparam int PW  = ((AW > W2) ? AW : W2) + 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_HDR_WR = 4'b0010,
    S_HDR_RD = 4'b0100,
    S_STREAM = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   read_ptr_r, read_ptr_nxt;
  logic [AW-1:0]   commit_ptr_r, commit_ptr_nxt;
  logic [AW-1:0]   fill_ptr_r, fill_ptr_nxt;
  logic [UW-1:0]   used_r, used_nxt;
  lprf_pkg::len_t  pend_r, pend_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_vld_r, out_vld_nxt;
  lprf_pkg::res_t  out_res_r, res_nxt;
  logic [AW-1:0]   hdr_addr_r, hdr_addr_nxt;
  lprf_pkg::len_t  hdr_len_r, hdr_len_nxt;
  logic            op_rm_r, op_rm_nxt;
  lprf_pkg::len_t  limit_r, limit_nxt;
  logic [AW-1:0]   pos_r, pos_nxt;
  lprf_pkg::len_t  cnt_r, cnt_nxt;

  lprf_pkg::byte_t mem_r [STORE_BYTES];
  lprf_pkg::byte_t rd_data_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  lprf_pkg::byte_t mem_wdata;

  logic            out_free, cmd_take;
  logic            too_long, no_room;
  logic [AW-1:0]   fill_v;
  lprf_pkg::len_t  pend_v;
  logic            ovf_v;
  logic [8:0]      len_p1;
  logic [W2-1:0]   span;
  logic [PW-1:0]   rd_sum, rd_wrap;
  logic [7:0]      lim8, cnt_min;
  lprf_pkg::len_t  rd_count;
  logic [AW-1:0]   first_pos;

  // Step a store address by one with wraparound
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    logic [AW-1:0] q;
    if (p == AW'(STORE_BYTES - 1)) begin
      q = '0;
    end else begin
      q = p + AW'(1);
    end
    return q;
  endfunction

  assign out_free  = !out_vld_r || out_ch.ready;
  assign cmd_ready = (state_r == S_IDLE) && out_free;
  assign cmd_take  = cmd_valid && cmd_ready;

  // Reject tests for the next pushed byte
  assign too_long = ({1'b0, pend_r} + 8'd1) > 8'(MAX_RECORD);
  assign no_room  = (SW'(used_r) + SW'(pend_r) + SW'(2)) > SW'(STORE_BYTES);

  // Header-derived read count, skip span and next read pointer
  assign len_p1    = {1'b0, rd_data_r} + 9'd1;
  assign span      = (W2'(len_p1) > W2'(used_r)) ? W2'(used_r) : W2'(len_p1);
  assign rd_sum    = PW'(read_ptr_r) + PW'(span);
  assign rd_wrap   = (rd_sum >= PW'(STORE_BYTES)) ? rd_sum - PW'(STORE_BYTES)
                                                  : rd_sum;
  assign lim8      = {1'b0, limit_r};
  assign cnt_min   = (lim8 < rd_data_r) ? lim8 : rd_data_r;
  assign rd_count  = (cnt_min > 8'(lprf_pkg::MAX_READ)) ?
                     lprf_pkg::LEN_W'(lprf_pkg::MAX_READ) : cnt_min[lprf_pkg::LEN_W-1:0];
  assign first_pos = ptr_inc(read_ptr_r);

  // Sequence operations
  always_comb begin
    state_nxt      = state_r;
    read_ptr_nxt   = read_ptr_r;
    commit_ptr_nxt = commit_ptr_r;
    fill_ptr_nxt   = fill_ptr_r;
    used_nxt       = used_r;
    pend_nxt       = pend_r;
    ovf_nxt        = ovf_r;
    hdr_addr_nxt   = hdr_addr_r;
    hdr_len_nxt    = hdr_len_r;
    op_rm_nxt      = op_rm_r;
    limit_nxt      = limit_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    res_nxt        = '0;
    fill_v         = fill_ptr_r;
    pend_v         = pend_r;
    ovf_v          = ovf_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_take) begin
          unique case (cmd.op)
            lprf_pkg::OP_PUSH: begin
              // Append the byte unless the record is already dropped
              if (!ovf_r) begin
                if (pend_r == '0) begin
                  fill_v = ptr_inc(commit_ptr_r);
                end
                if (too_long || no_room) begin
                  ovf_v = 1'b1;
                end else begin
                  mem_we    = 1'b1;
                  mem_waddr = fill_v;
                  mem_wdata = cmd.data;
                  fill_v    = ptr_inc(fill_v);
                  pend_v    = pend_r + lprf_pkg::LEN_W'(1);
                end
              end
              res_nxt.status = ovf_v ? lprf_pkg::STAT_FULL : lprf_pkg::STAT_OK;
              // Commit on the final byte; header goes in next cycle
              if (cmd.last) begin
                if (!ovf_v) begin
                  hdr_addr_nxt   = commit_ptr_r;
                  hdr_len_nxt    = pend_v;
                  commit_ptr_nxt = fill_v;
                  used_nxt       = UW'(SW'(used_r) + SW'(pend_v) + SW'(1));
                  state_nxt      = S_HDR_WR;
                end
                ovf_v  = 1'b0;
                pend_v = '0;
              end
              fill_ptr_nxt        = fill_v;
              pend_nxt            = pend_v;
              ovf_nxt             = ovf_v;
              res_nxt.run_last    = 1'b1;
              res_nxt.queue_empty = (used_nxt == '0);
            end
            lprf_pkg::OP_REMOVE, lprf_pkg::OP_PEEK: begin
              if (used_r == '0) begin
                res_nxt.status      = lprf_pkg::STAT_EMPTY;
                res_nxt.run_last    = 1'b1;
                res_nxt.queue_empty = 1'b1;
              end else begin
                // Fetch the oldest header
                mem_re    = 1'b1;
                mem_raddr = read_ptr_r;
                op_rm_nxt = (cmd.op == lprf_pkg::OP_REMOVE);
                limit_nxt = cmd.limit;
                state_nxt = S_HDR_RD;
              end
            end
            default: begin
              res_nxt.status      = lprf_pkg::STAT_OK;
              res_nxt.run_last    = 1'b1;
              res_nxt.queue_empty = (used_r == '0);
            end
          endcase
        end
      end
      S_HDR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = hdr_addr_r;
        mem_wdata = {1'b0, hdr_len_r};
        state_nxt = S_IDLE;
      end
      S_HDR_RD: begin
        if (rd_count != '0 || out_free) begin
          // Drop the whole record on remove
          if (op_rm_r) begin
            read_ptr_nxt = rd_wrap[AW-1:0];
            used_nxt     = used_r - UW'(span);
          end
          if (rd_count == '0) begin
            res_nxt.status      = lprf_pkg::STAT_OK;
            res_nxt.run_last    = 1'b1;
            res_nxt.queue_empty = (used_nxt == '0);
            state_nxt           = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = first_pos;
            pos_nxt   = ptr_inc(first_pos);
            cnt_nxt   = rd_count;
            state_nxt = S_STREAM;
          end
        end
      end
      S_STREAM: begin
        // Emit one payload byte and fetch the next while the output drains
        if (out_free) begin
          res_nxt.out_byte    = rd_data_r;
          res_nxt.byte_valid  = 1'b1;
          res_nxt.run_last    = (cnt_r == lprf_pkg::LEN_W'(1));
          res_nxt.status      = lprf_pkg::STAT_OK;
          res_nxt.queue_empty = (used_r == '0);
          if (cnt_r == lprf_pkg::LEN_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pos_r;
            pos_nxt   = ptr_inc(pos_r);
            cnt_nxt   = cnt_r - lprf_pkg::LEN_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Load the result register whenever a result is produced
  logic out_load;
  always_comb begin
    out_load = (cmd_take && !(cmd.op == lprf_pkg::OP_REMOVE && used_r != '0)
                         && !(cmd.op == lprf_pkg::OP_PEEK && used_r != '0))
            || (state_r == S_HDR_RD && rd_count == '0 && out_free)
            || (state_r == S_STREAM && out_free);
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      read_ptr_r   <= '0;
      commit_ptr_r <= '0;
      fill_ptr_r   <= '0;
      used_r       <= '0;
      pend_r       <= '0;
      ovf_r        <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      read_ptr_r   <= read_ptr_nxt;
      commit_ptr_r <= commit_ptr_nxt;
      fill_ptr_r   <= fill_ptr_nxt;
      used_r       <= used_nxt;
      pend_r       <= pend_nxt;
      ovf_r        <= ovf_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  // Hold operation context and result payload
  always_ff @(posedge clk) begin
    hdr_addr_r <= hdr_addr_nxt;
    hdr_len_r  <= hdr_len_nxt;
    op_rm_r    <= op_rm_nxt;
    limit_r    <= limit_nxt;
    pos_r      <= pos_nxt;
    cnt_r      <= cnt_nxt;
    if (out_load) begin
      out_res_r <= res_nxt;
    end
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem_r[mem_raddr];
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.out_byte    = out_res_r.out_byte;
  assign out_ch.byte_valid  = out_res_r.byte_valid;
  assign out_ch.run_last    = out_res_r.run_last;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.queue_empty = out_res_r.queue_empty;

endmodule

### rtl/length_prefixed_record_fifo.sv
// ----------------------------------------------------------------------------
// length_prefixed_record_fifo
// Circular byte store of variable-length records, each kept as a one-byte
// length header followed by its payload. Every request passes through a
// two-entry request queue before the execution logic takes it. A push byte
// then yields one result; the final byte of a committed record is followed
// by a header write through the store's single write port. Remove and peek
// fetch the header through the registered read port and decode it in the
// header-read state. With a zero count (count = min(read_limit, length,
// 64)) the single result is loaded from the header-read state; otherwise
// payload bytes stream out one per cycle while the result side keeps up.
// Empty-queue and unknown requests give a single result. The execution
// logic waits while a result is held in the output register, and the
// request queue keeps accepting until both of its entries are full. The
// store needs no clearing pass after reset: only bytes of committed records
// are ever read.
// ----------------------------------------------------------------------------
module length_prefixed_record_fifo #(
  parameter int STORE_BYTES = 256,
  parameter int MAX_RECORD  = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  lprf_in_if.sink    in_ch,
  lprf_out_if.source out_ch
);

  logic           cmd_valid;
  logic           cmd_ready;
  lprf_pkg::cmd_t cmd;

  // Accept and classify requests
  lprf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // Execute against the byte store
  lprf_back #(
    .STORE_BYTES (STORE_BYTES),
    .MAX_RECORD  (MAX_RECORD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_ch    (out_ch)
  );

  // An empty status always reports an empty queue and carries no byte
  a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == lprf_pkg::STAT_EMPTY
      |-> out_ch.queue_empty && !out_ch.byte_valid)
    else $error("empty status with queue_empty clear or a payload byte");

  // Payload bytes only come with an ok status
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.byte_valid |-> out_ch.status == lprf_pkg::STAT_OK)
    else $error("payload byte with a non-ok status");

  // A result without a byte is the sole result of its request
  a_nobyte_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.byte_valid
      |-> out_ch.run_last && out_ch.out_byte == 8'd0)
    else $error("byte-less result not marked last or carrying data");

endmodule
